// ----- rtl/time_slice_priority_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Time-slice priority scheduler: assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIME_SLICE_PRIORITY_SCHEDULER_DEFINES_SVH
`define TIME_SLICE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define TSPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tsps_pkg.sv -----
// ----------------------------------------------------------------------------
// Time-slice priority scheduler: package
// Sizes, control structs and controller states shared by all modules.
// ----------------------------------------------------------------------------
package tsps_pkg;

	// number of tasks, task 0 is the idle task
	localparam int TASK_COUNT = 4;
	// tasks that have a priority register
	localparam int PRIO_REGS  = 4;
	localparam int PRIO_W     = 4;
	localparam int RUN_W      = $clog2(TASK_COUNT + 1);
	localparam int CNT_W      = $clog2(TASK_COUNT + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_TASK_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRIO_TASK1 = 2'd0;

	// priority of a task with no register
	localparam logic [PRIO_W-1:0] PRIO_DEFAULT = 4'd1;

	// candidate passed from cell to cell during a scan
	typedef struct packed {
		logic [RUN_W-1:0]  idx;
		logic [PRIO_W-1:0] slice;
		logic [PRIO_W-1:0] prio;
	} cand_t;

	// broadcast control from the controller
	typedef struct packed {
		logic             charge;
		logic             reload;
		logic [RUN_W-1:0] idx;
	} sched_ctrl_t;

	// per-cell priority write
	typedef struct packed {
		logic              we;
		logic [PRIO_W-1:0] wdata;
	} prio_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/time_slice_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// Time-slice priority scheduler
// Keeps a remaining slice per task in a row of cells and picks the next task
// by passing a best-so-far candidate down the row.
//
//   channel  | dir | payload
//   ---------+-----+--------------------------------------------------
//   s_axis   | in  | tick
//   m_axis   | out | running_task, switched, reloaded
//   cfg      | in  | priority_task1..4 by index 0..3, write only
//
// A status query or a tick without a reschedule goes from ST_IDLE through
// ST_OUT to the output register. A reschedule first passes the candidate
// across the cell row in ST_SCAN, and a reload makes a second pass.
// One request is in work at a time; a new one is taken once the previous
// result is in the output register. Reset clears all slices, selects the
// idle task and sets every priority to 1.
// ----------------------------------------------------------------------------
module time_slice_priority_scheduler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [0] tick
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,   // [2:0] running_task, [3] switched,
	                                                      // [4] reloaded
	input  logic                               cfg_we,
	input  logic [tsps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsps_pkg::PRIO_W-1:0]        cfg_wdata
);
	import tsps_pkg::*;

	cand_t                 cand [TASK_COUNT+1];
	logic [PRIO_W-1:0]     slice [TASK_COUNT];
	prio_wr_t              prio_wr [TASK_COUNT];
	sched_ctrl_t           ctrl;
	logic [RUN_W-1:0]      running;
	logic [PRIO_W-1:0]     run_slice;
	logic [OUT_TASK_W-1:0] out_task;
	logic                  out_switched;
	logic                  out_reloaded;

	// empty candidate enters the head of the row
	assign cand[0] = '0;

	// priority write decode, tasks without a register keep their default
	always_comb begin
		for (int k = 0; k < TASK_COUNT; k++) begin
			prio_wr[k].wdata = cfg_wdata;
			if (k < PRIO_REGS) begin
				prio_wr[k].we = cfg_we &&
					(cfg_index == REG_PRIO_TASK1 + CFG_IDX_W'(k));
			end else begin
				prio_wr[k].we = 1'b0;
			end
		end
	end

	// slice of the running task, zero for the idle task
	always_comb begin
		run_slice = '0;
		for (int k = 0; k < TASK_COUNT; k++) begin
			if (running == RUN_W'(k + 1)) begin
				run_slice = slice[k];
			end
		end
	end

	// cell row
	for (genvar k = 0; k < TASK_COUNT; k++) begin : g_cell
		tsps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_id  (RUN_W'(k + 1)),
			.ctrl     (ctrl),
			.prio_wr  (prio_wr[k]),
			.cand_in  (cand[k]),
			.cand_out (cand[k+1]),
			.slice    (slice[k])
		);
	end

	tsps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.tick         (s_tdata[0]),
		.run_slice    (run_slice),
		.tail         (cand[TASK_COUNT]),
		.ctrl         (ctrl),
		.running      (running),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_task     (out_task),
		.out_switched (out_switched),
		.out_reloaded (out_reloaded)
	);

	assign m_tdata = {3'b000, out_reloaded, out_switched, out_task};

endmodule

// ----- rtl/tsps_cell.sv -----
// ----------------------------------------------------------------------------
// Time-slice priority scheduler: task cell
// Holds one task's priority and remaining slice, and compares itself against
// the candidate handed in by its left neighbor every cycle.
// ----------------------------------------------------------------------------
module tsps_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [tsps_pkg::RUN_W-1:0]   cell_id,
	input  tsps_pkg::sched_ctrl_t        ctrl,
	input  tsps_pkg::prio_wr_t           prio_wr,
	input  tsps_pkg::cand_t              cand_in,
	output tsps_pkg::cand_t              cand_out,
	output logic [tsps_pkg::PRIO_W-1:0]  slice
);
	import tsps_pkg::*;

	logic [PRIO_W-1:0] prio_q;
	logic [PRIO_W-1:0] slice_q;
	cand_t             cand_q;
	logic              take;

	// priority register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= PRIO_DEFAULT;
		end else if (prio_wr.we) begin
			prio_q <= prio_wr.wdata;
		end
	end

	// remaining slice: reload from priority or charge one unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= '0;
		end else if (ctrl.reload) begin
			slice_q <= prio_q;
		end else if (ctrl.charge && ctrl.idx == cell_id && slice_q != '0) begin
			slice_q <= slice_q - 1'b1;
		end
	end

	// larger slice wins, then higher priority; equal keeps the lower index
	assign take = (slice_q > cand_in.slice) ||
		(slice_q == cand_in.slice && prio_q > cand_in.prio);

	always_ff @(posedge clk) begin
		if (take) begin
			cand_q <= '{idx: cell_id, slice: slice_q, prio: prio_q};
		end else begin
			cand_q <= cand_in;
		end
	end

	assign cand_out = cand_q;
	assign slice    = slice_q;

endmodule

// ----- rtl/tsps_ctrl.sv -----
// ----------------------------------------------------------------------------
// Time-slice priority scheduler: controller
// Takes requests, charges the running task, waits for the cell row to
// settle, reloads when every slice is spent, and holds the result register.
// ----------------------------------------------------------------------------
module tsps_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             tick,
	input  logic [tsps_pkg::PRIO_W-1:0]      run_slice,
	input  tsps_pkg::cand_t                  tail,
	output tsps_pkg::sched_ctrl_t            ctrl,
	output logic [tsps_pkg::RUN_W-1:0]       running,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tsps_pkg::OUT_TASK_W-1:0]  out_task,
	output logic                             out_switched,
	output logic                             out_reloaded
);
	import tsps_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [RUN_W-1:0]  running_q, running_d;
	logic [RUN_W-1:0]  before_q, before_d;
	logic              reload_q, reload_d;
	logic              out_valid_q;
	logic [OUT_TASK_W-1:0] out_task_q;
	logic              out_switched_q;
	logic              out_reloaded_q;
	logic              accept;
	logic              load_out;
	logic              resched;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign resched  = (running_q == '0) || (run_slice <= PRIO_W'(1));

	// next state and broadcast control
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		running_d   = running_q;
		before_d    = before_q;
		reload_d    = reload_q;
		ctrl        = '{charge: 1'b0, reload: 1'b0, idx: running_q};
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					before_d = running_q;
					reload_d = 1'b0;
					cnt_d    = '0;
					ctrl.charge = tick;
					if (tick && resched) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(TASK_COUNT)) begin
					if (tail.slice == '0 && !reload_q) begin
						// every slice spent: reload and scan once more
						ctrl.reload = 1'b1;
						reload_d    = 1'b1;
						cnt_d       = '0;
					end else begin
						running_d = (tail.slice == '0) ? '0 : tail.idx;
						state_d   = ST_OUT;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			running_q   <= '0;
			before_q    <= '0;
			reload_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			running_q <= running_d;
			before_q  <= before_d;
			reload_q  <= reload_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_task_q     <= OUT_TASK_W'(running_q);
			out_switched_q <= (running_q != before_q);
			out_reloaded_q <= reload_q;
		end
	end

	assign running      = running_q;
	assign out_valid    = out_valid_q;
	assign out_task     = out_task_q;
	assign out_switched = out_switched_q;
	assign out_reloaded = out_reloaded_q;

endmodule

// ----- rtl/tsps_checker.sv -----
// ----------------------------------------------------------------------------
// Time-slice priority scheduler: port checker
// Watches the result stream of the top level over time.
// ----------------------------------------------------------------------------
`include "time_slice_priority_scheduler_defines.svh"

module tsps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);
	import tsps_pkg::*;

	logic [2:0] last_task_q;

	// running task of the last delivered result, idle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_task_q <= '0;
		end else if (m_tvalid && m_tready) begin
			last_task_q <= m_tdata[2:0];
		end
	end

	// a stalled result holds
	`TSPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// only existing tasks run
	`TSPS_ASSERT_NOW(a_task_range, m_tvalid, {1'b0, m_tdata[2:0]} <= 4'(TASK_COUNT), "running task out of range")

	// switched flag agrees with the previous result
	`TSPS_ASSERT_NOW(a_switch_flag, m_tvalid && (TASK_COUNT < 8), m_tdata[3] == (m_tdata[2:0] != last_task_q), "switched flag disagrees with task change")

	// padding bits stay zero
	`TSPS_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[7:5] == 3'b000, "result padding not zero")

endmodule

bind time_slice_priority_scheduler tsps_checker u_tsps_checker (.*);
